>>> src/md5_stream_hasher_core_assert.svh
// assertion macros shared by the md5 stream hasher rtl
`ifndef MD5_STREAM_HASHER_CORE_ASSERT_SVH
`define MD5_STREAM_HASHER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MD5SH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MD5SH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/md5sh_pkg.sv
// types, round constants and schedule functions of the md5 stream hasher
package md5sh_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [3:0] t_quad;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } t_pad_stage;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] idx;
    } t_round_ctl;

    localparam t_word IV_A = 32'h67452301;
    localparam t_word IV_B = 32'hefcdab89;
    localparam t_word IV_C = 32'h98badcfe;
    localparam t_word IV_D = 32'h10325476;

    localparam t_word ROUND_K [64] = '{
        32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
        32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
        32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
        32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
        32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
        32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
        32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
        32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
        32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
        32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
        32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
        32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
        32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
        32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
        32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
        32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
    };

    // rotate amount repeats every four rounds within each group of sixteen
    function automatic logic [4:0] f_rot_amt(input logic [5:0] idx);
        logic [4:0] amt;
        amt = 5'd0;
        unique case ({idx[5:4], idx[1:0]})
            4'b00_00: amt = 5'd7;
            4'b00_01: amt = 5'd12;
            4'b00_10: amt = 5'd17;
            4'b00_11: amt = 5'd22;
            4'b01_00: amt = 5'd5;
            4'b01_01: amt = 5'd9;
            4'b01_10: amt = 5'd14;
            4'b01_11: amt = 5'd20;
            4'b10_00: amt = 5'd4;
            4'b10_01: amt = 5'd11;
            4'b10_10: amt = 5'd16;
            4'b10_11: amt = 5'd23;
            4'b11_00: amt = 5'd6;
            4'b11_01: amt = 5'd10;
            4'b11_10: amt = 5'd15;
            4'b11_11: amt = 5'd21;
        endcase
        return amt;
    endfunction

    // message word index used by a round
    function automatic logic [3:0] f_msg_idx(input logic [5:0] idx);
        logic [7:0] prod;
        logic [3:0] g;
        prod = 8'd0;
        unique case (idx[5:4])
            2'd0: prod = {2'b00, idx};
            2'd1: prod = 8'd5 * {2'b00, idx} + 8'd1;
            2'd2: prod = 8'd3 * {2'b00, idx} + 8'd5;
            2'd3: prod = 8'd7 * {2'b00, idx};
        endcase
        g = prod[3:0];
        return g;
    endfunction

endpackage

>>> src/md5sh_buf.sv
// 16 x 32 message block memory, one write port, one registered read port
module md5sh_buf (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [3:0]           i_wr_addr,
    input  md5sh_pkg::t_word     i_wr_data,
    input  logic [3:0]           i_rd_addr,
    output md5sh_pkg::t_word     o_rd_data
);

    md5sh_pkg::t_word r_mem [16];
    md5sh_pkg::t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/md5sh_round.sv
// md5 round datapath: working words a b c d, one round per cycle while step is set
module md5sh_round (
    input  logic                   i_clk,
    input  md5sh_pkg::t_round_ctl  i_ctl,
    input  md5sh_pkg::t_quad       i_chain,
    input  md5sh_pkg::t_word       i_msg,
    output md5sh_pkg::t_quad       o_work
);

    md5sh_pkg::t_word r_a, r_b, r_c, r_d;
    // a plus round constant, prepared one round ahead
    md5sh_pkg::t_word r_ak;

    md5sh_pkg::t_word f_val;
    md5sh_pkg::t_word sum;
    logic [63:0]      dbl;
    md5sh_pkg::t_word n_b;
    logic [5:0]       idx_nx;

    always_comb begin
        f_val = '0;
        unique case (i_ctl.idx[5:4])
            2'd0: f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1: f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2: f_val = r_b ^ r_c ^ r_d;
            2'd3: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sum    = f_val + r_ak + i_msg;
        dbl    = {sum, sum} << md5sh_pkg::f_rot_amt(i_ctl.idx);
        n_b    = r_b + dbl[63:32];
        idx_nx = i_ctl.idx + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a  <= i_chain[0];
            r_b  <= i_chain[1];
            r_c  <= i_chain[2];
            r_d  <= i_chain[3];
            r_ak <= i_chain[0] + md5sh_pkg::ROUND_K[0];
        end else if (i_ctl.step) begin
            r_a  <= r_d;
            r_b  <= n_b;
            r_c  <= r_b;
            r_d  <= r_c;
            r_ak <= r_d + md5sh_pkg::ROUND_K[idx_nx];
        end
    end

    assign o_work = {r_d, r_c, r_b, r_a};

endmodule

>>> src/md5_stream_hasher_core.sv
// md5 stream hasher top level: byte intake, padding, round sequencing, digest output
//
// Computes the MD5 digest of a message streamed one byte per input transfer.
// A transfer with i_has_byte high carries a byte; one with i_last high ends
// the message (i_last with i_has_byte low ends it with no byte, so a lone
// end marker gives the digest of the empty message). Bytes are packed into
// 32-bit little-endian words and written to a 16-word block memory. When
// the 64th byte of a block lands, the block is compressed (a prefetch, 64
// rounds at one per cycle through the round datapath, a chaining add),
// during which o_stall is high. At message end the pad byte, zero fill
// and 64-bit bit length are written one byte per cycle, and the tail then
// needs one or two compressions. The digest is then delivered as two transfers:
// bytes 0..7 first (o_is_last low), bytes 8..15 second (o_is_last high),
// first digest byte in bits 63:56. The hasher is ready for the next message
// while the digest still waits on the output. Message length wraps modulo
// 2^64 bits. The block memory needs no clearing after reset.
module md5_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_half,
    output logic        o_is_last
);

    // control state
    md5sh_pkg::t_state     r_state, n_state;
    md5sh_pkg::t_pad_stage r_pad_stage, n_pad_stage;
    logic                  r_pad_active, n_pad_active;   // padding still owed
    logic                  r_final, n_final;             // current block ends the message
    logic [5:0]            r_idx, n_idx;                 // round number
    logic [5:0]            r_pos;                        // byte position in block
    logic [63:0]           r_count;                      // message bytes so far
    logic [23:0]           r_word;                       // lower three bytes of word in assembly
    md5sh_pkg::t_quad      r_chain;

    // output register
    logic                  r_out_valid;
    logic                  r_out_half;
    logic [127:0]          r_dig;

    // datapath
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  put;                          // a byte is written this cycle
    logic                  put_msg;                      // ...and it is a message byte
    logic [7:0]            put_byte;
    logic                  pad_len;
    logic [63:0]           bit_len;
    logic                  chain_add;
    logic                  dig_load;
    logic                  wr_en;
    logic [3:0]            rd_addr;
    md5sh_pkg::t_word      rd_data;
    md5sh_pkg::t_quad      work;
    md5sh_pkg::t_round_ctl round_ctl;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // the length field starts at position 56 once the zero fill reaches it
    assign pad_len = (r_pad_stage == md5sh_pkg::PAD_LEN) ||
                     ((r_pad_stage == md5sh_pkg::PAD_ZERO) && (r_pos == 6'd56));
    assign bit_len = {r_count[60:0], 3'b000};

    always_comb begin
        priority if (r_pad_stage == md5sh_pkg::PAD_MARK) begin
            put_byte = 8'h80;
        end else if (pad_len) begin
            put_byte = bit_len[{r_pos[2:0], 3'b000} +: 8];
        end else begin
            put_byte = 8'h00;
        end
        if (r_state != md5sh_pkg::S_PAD) begin
            put_byte = i_data_byte;
        end
    end

    // next state and control
    always_comb begin
        n_state      = r_state;
        n_pad_stage  = r_pad_stage;
        n_pad_active = r_pad_active;
        n_final      = r_final;
        n_idx        = r_idx;
        o_stall      = 1'b1;
        put          = 1'b0;
        put_msg      = 1'b0;
        chain_add    = 1'b0;
        dig_load     = 1'b0;
        round_ctl    = '{load: 1'b0, step: 1'b0, idx: r_idx};
        rd_addr      = md5sh_pkg::f_msg_idx(6'd0);
        unique case (r_state)
            md5sh_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (in_xfer) begin
                    put     = i_has_byte;
                    put_msg = i_has_byte;
                    if (i_last) begin
                        n_pad_active = 1'b1;
                        n_pad_stage  = md5sh_pkg::PAD_MARK;
                    end
                    priority if (i_has_byte && (r_pos == 6'd63)) begin
                        n_state = md5sh_pkg::S_LOAD;
                    end else if (i_last) begin
                        n_state = md5sh_pkg::S_PAD;
                    end
                end
            end
            md5sh_pkg::S_PAD: begin
                put = 1'b1;
                priority if (r_pad_stage == md5sh_pkg::PAD_MARK) begin
                    n_pad_stage = md5sh_pkg::PAD_ZERO;
                end else if (pad_len) begin
                    n_pad_stage = md5sh_pkg::PAD_LEN;
                end
                if (r_pos == 6'd63) begin
                    n_state = md5sh_pkg::S_LOAD;
                    n_final = pad_len;
                end
            end
            md5sh_pkg::S_LOAD: begin
                // prefetch the first round's word
                round_ctl.load = 1'b1;
                n_idx          = 6'd0;
                n_state        = md5sh_pkg::S_ROUND;
            end
            md5sh_pkg::S_ROUND: begin
                round_ctl.step = 1'b1;
                rd_addr        = md5sh_pkg::f_msg_idx(r_idx + 6'd1);
                n_idx          = r_idx + 6'd1;
                if (r_idx == 6'd63) begin
                    n_state = md5sh_pkg::S_ADD;
                end
            end
            md5sh_pkg::S_ADD: begin
                chain_add = 1'b1;
                priority if (r_final) begin
                    n_state = md5sh_pkg::S_DONE;
                end else if (r_pad_active) begin
                    n_state = md5sh_pkg::S_PAD;
                end else begin
                    n_state = md5sh_pkg::S_IDLE;
                end
            end
            md5sh_pkg::S_DONE: begin
                // wait until the previous digest has left
                if (!r_out_valid) begin
                    dig_load     = 1'b1;
                    n_final      = 1'b0;
                    n_pad_active = 1'b0;
                    n_pad_stage  = md5sh_pkg::PAD_MARK;
                    n_state      = md5sh_pkg::S_IDLE;
                end
            end
            default: n_state = md5sh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= md5sh_pkg::S_IDLE;
            r_pad_stage  <= md5sh_pkg::PAD_MARK;
            r_pad_active <= 1'b0;
            r_final      <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_pad_stage  <= n_pad_stage;
            r_pad_active <= n_pad_active;
            r_final      <= n_final;
            r_idx        <= n_idx;
        end
    end

    // byte position, length count and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_chain <= {md5sh_pkg::IV_D, md5sh_pkg::IV_C, md5sh_pkg::IV_B, md5sh_pkg::IV_A};
        end else begin
            if (dig_load) begin
                r_pos   <= '0;
                r_count <= '0;
                r_chain <= {md5sh_pkg::IV_D, md5sh_pkg::IV_C,
                            md5sh_pkg::IV_B, md5sh_pkg::IV_A};
            end else begin
                if (put) begin
                    r_pos <= r_pos + 6'd1;
                end
                if (put_msg) begin
                    r_count <= r_count + 64'd1;
                end
                if (chain_add) begin
                    r_chain[0] <= r_chain[0] + work[0];
                    r_chain[1] <= r_chain[1] + work[1];
                    r_chain[2] <= r_chain[2] + work[2];
                    r_chain[3] <= r_chain[3] + work[3];
                end
            end
        end
    end

    // little-endian word assembly, the top byte goes straight to memory
    always_ff @(posedge i_clk) begin
        if (put) begin
            unique case (r_pos[1:0])
                2'd0: r_word[7:0]   <= put_byte;
                2'd1: r_word[15:8]  <= put_byte;
                2'd2: r_word[23:16] <= put_byte;
                2'd3: r_word        <= r_word;
            endcase
        end
    end

    assign wr_en = put && (r_pos[1:0] == 2'd3);

    // digest output, two transfers per message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_half  <= 1'b0;
        end else begin
            priority if (dig_load) begin
                r_out_valid <= 1'b1;
                r_out_half  <= 1'b0;
            end else if (out_xfer) begin
                r_out_valid <= !r_out_half;
                r_out_half  <= !r_out_half;
            end
        end
    end

    // chaining words are little-endian, the digest string is byte order
    always_ff @(posedge i_clk) begin
        if (dig_load) begin
            r_dig <= {r_chain[0][7:0], r_chain[0][15:8], r_chain[0][23:16], r_chain[0][31:24],
                      r_chain[1][7:0], r_chain[1][15:8], r_chain[1][23:16], r_chain[1][31:24],
                      r_chain[2][7:0], r_chain[2][15:8], r_chain[2][23:16], r_chain[2][31:24],
                      r_chain[3][7:0], r_chain[3][15:8], r_chain[3][23:16], r_chain[3][31:24]};
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_last     = r_out_half;
    assign o_digest_half = r_out_half ? r_dig[63:0] : r_dig[127:64];

    md5sh_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pos[5:2]),
        .i_wr_data ({put_byte, r_word}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    md5sh_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (round_ctl),
        .i_chain (r_chain),
        .i_msg   (rd_data),
        .o_work  (work)
    );

`include "md5_stream_hasher_core_assert.svh"

    // rounds run back to back without a gap
`MD5SH_ASSERT_NEXT(a_round_seq, (r_state == md5sh_pkg::S_ROUND) && (r_idx != 6'd63), (r_state == md5sh_pkg::S_ROUND) && (r_idx == $past(r_idx) + 6'd1), "round sequence broken")
    // block memory is frozen while a block is compressed
`MD5SH_ASSERT_NOW(a_no_wr_comp, (r_state == md5sh_pkg::S_LOAD) || (r_state == md5sh_pkg::S_ROUND) || (r_state == md5sh_pkg::S_ADD), !wr_en, "block memory written during compression")
    // a captured digest starts with its first half
`MD5SH_ASSERT_NEXT(a_dig_first, (r_state == md5sh_pkg::S_DONE) && !r_out_valid, o_valid && !o_is_last, "digest not presented from first half")
    // the second half ends the digest, nothing follows it at once
`MD5SH_ASSERT_NEXT(a_dig_end, o_valid && o_is_last && !i_stall, !o_valid, "extra result after digest end")

endmodule

>>> sim/md5_stream_hasher_core_tb.sv
// self-checking testbench for the md5 stream hasher core: directed and random messages
module md5_stream_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1450;  // byte and end-marker transfers in the random part
    localparam int GAP_MAX     = 5;     // longest idle stretch drawn by either side
    localparam int DRAIN_WAIT  = 300;   // covers tail padding plus two compressions

    // ------------------------------------------------------------------
    // digest predictor and scoreboard
    // keeps its own md5 state, absorbs every accepted input transfer and
    // queues the two digest transfers a finished message must produce
    // ------------------------------------------------------------------
    class md5_scoreboard;
        typedef struct packed {
            logic [63:0] digest_half;
            logic        is_last;
        } t_digest_xfer;

        bit [31:0]    sine_k [64];
        int           rot_tab [16];
        bit [31:0]    chain [4];
        bit [31:0]    block_words [16];
        bit [63:0]    msg_bytes;
        t_digest_xfer digest_q [$];
        int           mismatches;

        function new();
            sine_k = '{
                32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
                32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
                32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
                32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
                32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
                32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
                32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
                32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
                32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
                32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
                32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
                32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
                32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
                32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
                32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
                32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
            };
            // rotate amounts, four per round group
            rot_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            mismatches = 0;
            start_message();
        endfunction

        function void start_message();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            msg_bytes = '0;
        endfunction

        function void compress();
            bit [31:0] a, b, c, d, f;
            int        g, s, i;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (i = 0; i < 64; i++) begin
                case (i / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1: begin
                        f = (d & b) | (~d & c);
                        g = (5 * i + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                f = f + a + sine_k[i] + block_words[g];
                s = rot_tab[(i / 16) * 4 + i % 4];
                a = d;
                d = c;
                c = b;
                b = b + ((f << s) | (f >> (32 - s)));
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // little-endian packing into the block; the last byte of a block compresses it
        function void put_byte(int pos, bit [7:0] v);
            if (pos % 4 == 0)
                block_words[pos / 4] = {24'h0, v};
            else
                block_words[pos / 4] |= {24'h0, v} << (8 * (pos % 4));
            if (pos == 63)
                compress();
        endfunction

        function bit [31:0] byte_swap(bit [31:0] v);
            return {v[7:0], v[15:8], v[23:16], v[31:24]};
        endfunction

        function void absorb_item(bit [7:0] data, bit has_byte, bit last);
            int           pos;
            bit [63:0]    bit_len;
            t_digest_xfer xfer;
            if (has_byte) begin
                put_byte(int'(msg_bytes[5:0]), data);
                msg_bytes++;
            end
            if (!last)
                return;
            pos = int'(msg_bytes[5:0]);
            put_byte(pos, 8'h80);
            pos = (pos + 1) % 64;
            while (pos != 56) begin
                put_byte(pos, 8'h00);
                pos = (pos + 1) % 64;
            end
            bit_len = msg_bytes << 3;
            for (int k = 0; k < 8; k++)
                put_byte(56 + k, bit_len[8 * k +: 8]);
            xfer.digest_half = {byte_swap(chain[0]), byte_swap(chain[1])};
            xfer.is_last = 1'b0;
            digest_q = {digest_q, xfer};
            xfer.digest_half = {byte_swap(chain[2]), byte_swap(chain[3])};
            xfer.is_last = 1'b1;
            digest_q = {digest_q, xfer};
            start_message();
        endfunction

        function void compare_digest(logic [63:0] digest_half, logic is_last);
            t_digest_xfer want;
            if (digest_q.size() == 0) begin
                $error("digest transfer with none expected: digest_half %h is_last %b",
                       digest_half, is_last);
                mismatches++;
                return;
            end
            want = digest_q.pop_front();
            if (digest_half !== want.digest_half) begin
                $error("digest_half mismatch: expected %h, actual %h",
                       want.digest_half, digest_half);
                mismatches++;
            end
            if (is_last !== want.is_last) begin
                $error("is_last mismatch: expected %b, actual %b", want.is_last, is_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_digest_half;
    logic        o_is_last;

    md5_scoreboard sb = new();

    always #4 i_clk = ~i_clk;

    md5_stream_hasher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_half (o_digest_half),
        .o_is_last     (o_is_last)
    );

    // ------------------------------------------------------------------
    // input side helpers
    // every task is entered and left at a falling edge, so valid gets at
    // most one update per time step even when transfers run back to back
    // ------------------------------------------------------------------
    function automatic int draw_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic has_byte,
                             input logic last, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_has_byte  <= has_byte;
        i_last      <= last;
        // hold the payload until the hasher stops stalling
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.absorb_item(data, has_byte, last);
        @(negedge i_clk);
    endtask

    // park the input side until every queued digest has been taken
    task automatic wait_digests_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // one message of the given length; the end comes either on the final
    // byte or as a separate empty end marker, with stray idle transfers mixed in
    task automatic send_message(input int len, input bit no_idle);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, draw_gap(no_idle));
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (j == len - 1),
                      draw_gap(no_idle));
        end
        if (!end_on_byte)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, draw_gap(no_idle));
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int sent;
        int msgs;
        int len;
        int pick;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle transfer alone changes nothing
        send_item(8'hA5, 1'b0, 1'b0, 0);
        // empty end marker right after reset gives the digest of the empty message
        send_item(8'h00, 1'b0, 1'b1, 0);
        // single byte carrying the end, both extremes of the byte value
        send_item(8'h00, 1'b1, 1'b1, 1);
        send_item(8'hFF, 1'b1, 1'b1, 0);
        // byte followed by a separate empty end marker
        send_item(8'hFF, 1'b1, 1'b0, 2);
        send_item(8'h3C, 1'b0, 1'b1, 0);
        // "abc" with an idle transfer in the middle, end on the last byte
        send_item(8'h61, 1'b1, 1'b0, 0);
        send_item(8'hFF, 1'b0, 1'b0, 0);
        send_item(8'h62, 1'b1, 1'b0, 3);
        send_item(8'h63, 1'b1, 1'b1, 0);
        // back-to-back empty messages
        send_item(8'hFF, 1'b0, 1'b1, 0);
        send_item(8'h00, 1'b0, 1'b1, 0);
        // alternating bit patterns then end
        send_item(8'h55, 1'b1, 1'b0, 0);
        send_item(8'hAA, 1'b1, 1'b1, 0);
        wait_digests_drained();

        // random messages; lengths lean on either side of the pad boundaries (55, 56, 63, 64 ...)
        // where the tail starts or stops needing a second compression
        sent = 0;
        msgs = 0;
        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 12);
            else if (pick < 90) begin
                case ($urandom_range(0, 9))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    7: len = 120;
                    8: len = 127;
                    default: len = 128;
                endcase
            end else
                len = $urandom_range(13, 130);
            send_message(len, $urandom_range(0, 3) == 0);
            sent += len + 1;
            msgs++;
            // let the output side catch up now and then
            if (msgs % 8 == 0)
                wait_digests_drained();
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0)
            @(negedge i_clk);
        // catch any stray transfer after the last digest
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: random stall before each transfer, with calm stretches
    // ------------------------------------------------------------------
    initial begin
        int  hold;
        int  taken;
        bit  calm;

        taken = 0;
        calm = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 10 == 0)
                calm = ($urandom_range(0, 2) == 0);
            hold = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            sb.compare_digest(o_digest_half, o_is_last);
            taken++;
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/md5sh_pkg.sv
src/md5sh_buf.sv
src/md5sh_round.sv
src/md5_stream_hasher_core.sv
sim/md5_stream_hasher_core_tb.sv
